// File: rtl/core/tcacl_pkg.sv
// Shared types, constants and helper functions for the text cursor layout block.
`timescale 1ns / 1ps
package tcacl_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int EXT_WIDTH   = 34;

  localparam logic [7:0] GLYPH_BASE = 8'd33;
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] SPACE      = 8'h20;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_M     = 8'h6D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] LVL_OFF  = 2'd0;
  localparam logic [1:0] LVL_HALF = 2'd1;
  localparam logic [1:0] LVL_FULL = 2'd2;
  localparam logic [5:0] WHITE_COLOR = {LVL_FULL, LVL_FULL, LVL_FULL};
  localparam logic [5:0] GREY_COLOR  = {LVL_HALF, LVL_HALF, LVL_HALF};

  localparam logic [5:0] CHAR_ADVANCE_RESET = 6'd9;
  localparam logic [7:0] LINE_STEP_RESET    = 8'd4;

  localparam logic [7:0] REG_CHAR_ADVANCE = 8'd0;
  localparam logic [7:0] REG_LINE_STEP    = 8'd1;

  localparam logic signed [EXT_WIDTH-1:0] COORD_MAX =
    EXT_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EXT_WIDTH-1:0] COORD_MIN = -COORD_MAX - EXT_WIDTH'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_NEWLINE,
    OP_ADVANCE,
    OP_GLYPH,
    OP_COLOR
  } op_t;

  // One classified request passed from the front to the back.
  typedef struct packed {
    op_t        op;
    coord_t     pos_x;
    coord_t     pos_y;
    logic [7:0] code;
  } entry_t;

  // Clamp a wide signed value into the coordinate range.
  function automatic coord_t sat_coord(input logic signed [EXT_WIDTH-1:0] v);
    coord_t r;
    if (v > COORD_MAX) r = COORD_WIDTH'(COORD_MAX);
    else if (v < COORD_MIN) r = COORD_WIDTH'(COORD_MIN);
    else r = COORD_WIDTH'(v);
    return r;
  endfunction

  // Low 16 bits of a coordinate, sign extended first when coordinates are narrower.
  function automatic logic [15:0] coord_to_out(input coord_t c);
    logic signed [EXT_WIDTH-1:0] w;
    w = EXT_WIDTH'(c);
    return w[15:0];
  endfunction

endpackage

// File: rtl/core/tcacl_front.sv
// Front end: accepts bytes, tracks escape sequences and classifies requests.
`timescale 1ns / 1ps
module tcacl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [7:0]        char_code,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  output logic              push_valid,
  input  logic              push_ready,
  output tcacl_pkg::entry_t push_data
);

  logic [2:0] esc_count;
  logic [7:0] esc_bytes [3];

  logic       accept;
  logic       color_hit;
  logic [5:0] color_value;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Decode a complete four-byte sequence; the last byte is the current one.
  always_comb begin
    logic [2:0] c;
    logic [1:0] lvl;
    c           = esc_bytes[2][2:0];
    lvl         = tcacl_pkg::LVL_HALF;
    color_hit   = 1'b0;
    color_value = tcacl_pkg::WHITE_COLOR;
    if (esc_bytes[0] == tcacl_pkg::CHAR_LBRACKET && char_code == tcacl_pkg::CHAR_M &&
        esc_bytes[2] inside {[tcacl_pkg::CHAR_ZERO : tcacl_pkg::CHAR_SEVEN]}) begin
      if (esc_bytes[1] == tcacl_pkg::CHAR_THREE) begin
        color_hit = 1'b1;
        lvl       = tcacl_pkg::LVL_HALF;
      end else if (esc_bytes[1] == tcacl_pkg::CHAR_NINE) begin
        color_hit = 1'b1;
        lvl       = tcacl_pkg::LVL_FULL;
      end
      color_value = {c[0] ? lvl : tcacl_pkg::LVL_OFF,
                     c[1] ? lvl : tcacl_pkg::LVL_OFF,
                     c[2] ? lvl : tcacl_pkg::LVL_OFF};
      if (esc_bytes[1] == tcacl_pkg::CHAR_NINE && c == 3'd0) begin
        color_value = tcacl_pkg::GREY_COLOR;
      end
    end
  end

  always_comb begin
    push_data.op    = tcacl_pkg::OP_GLYPH;
    push_data.pos_x = tcacl_pkg::sat_coord(tcacl_pkg::EXT_WIDTH'(start_x));
    push_data.pos_y = tcacl_pkg::sat_coord(tcacl_pkg::EXT_WIDTH'(start_y));
    push_data.code  = char_code - tcacl_pkg::GLYPH_BASE;
    push_valid      = 1'b0;
    if (!cmd) begin
      push_data.op = tcacl_pkg::OP_START;
      push_valid   = in_valid;
    end else if (esc_count != 3'd0) begin
      push_data.op   = tcacl_pkg::OP_COLOR;
      push_data.code = {2'b00, color_value};
      push_valid     = in_valid && esc_count >= 3'd4 && color_hit;
    end else if (char_code == tcacl_pkg::NEWLINE) begin
      push_data.op = tcacl_pkg::OP_NEWLINE;
      push_valid   = in_valid;
    end else if (char_code == tcacl_pkg::SPACE) begin
      push_data.op = tcacl_pkg::OP_ADVANCE;
      push_valid   = in_valid;
    end else if (char_code >= tcacl_pkg::GLYPH_BASE) begin
      push_valid = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_count <= 3'd0;
    end else if (accept) begin
      if (!cmd) begin
        esc_count <= 3'd0;
      end else if (esc_count != 3'd0) begin
        esc_count <= (esc_count >= 3'd4) ? 3'd0 : esc_count + 3'd1;
      end else if (char_code == tcacl_pkg::ESC_BYTE) begin
        esc_count <= 3'd1;
      end
    end
  end

  // Sequence bytes need no reset; they are always written before being decoded.
  always_ff @(posedge clk) begin
    if (accept && cmd) begin
      case (esc_count)
        3'd1: esc_bytes[0] <= char_code;
        3'd2: esc_bytes[1] <= char_code;
        3'd3: esc_bytes[2] <= char_code;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tcacl_queue.sv
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module tcacl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  tcacl_pkg::entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tcacl_pkg::entry_t pop_data
);

  tcacl_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/core/tcacl_back.sv
// Back end: holds cursor, color and settings, and registers glyph records.
`timescale 1ns / 1ps
module tcacl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  tcacl_pkg::entry_t pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [15:0] glyph_x,
  output logic signed [15:0] glyph_y,
  output logic [7:0]        glyph_index,
  output logic [1:0]        red_level,
  output logic [1:0]        green_level,
  output logic [1:0]        blue_level
);

  logic [5:0]        char_advance;
  logic [7:0]        line_step;
  tcacl_pkg::coord_t cursor_x;
  tcacl_pkg::coord_t cursor_y;
  tcacl_pkg::coord_t line_start_x;
  logic [5:0]        current_color;

  logic              out_free;
  logic              do_pop;
  tcacl_pkg::coord_t x_advanced;
  tcacl_pkg::coord_t y_stepped;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  // Only a glyph request needs room in the output register.
  assign pop_ready = (pop_data.op != tcacl_pkg::OP_GLYPH) || out_free;
  assign do_pop    = pop_valid && pop_ready;

  assign x_advanced = tcacl_pkg::sat_coord(tcacl_pkg::EXT_WIDTH'(cursor_x) +
                                           tcacl_pkg::EXT_WIDTH'(char_advance));
  assign y_stepped  = tcacl_pkg::sat_coord(tcacl_pkg::EXT_WIDTH'(cursor_y) -
                                           tcacl_pkg::EXT_WIDTH'(line_step));

  always_ff @(posedge clk) begin
    if (rst) begin
      char_advance <= tcacl_pkg::CHAR_ADVANCE_RESET;
      line_step    <= tcacl_pkg::LINE_STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcacl_pkg::REG_CHAR_ADVANCE: char_advance <= cfg_data[5:0];
        tcacl_pkg::REG_LINE_STEP:    line_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= '0;
      cursor_y      <= '0;
      line_start_x  <= '0;
      current_color <= tcacl_pkg::WHITE_COLOR;
    end else if (do_pop) begin
      case (pop_data.op)
        tcacl_pkg::OP_START: begin
          cursor_x      <= pop_data.pos_x;
          cursor_y      <= pop_data.pos_y;
          line_start_x  <= pop_data.pos_x;
          current_color <= tcacl_pkg::WHITE_COLOR;
        end
        tcacl_pkg::OP_NEWLINE: begin
          cursor_x <= line_start_x;
          cursor_y <= y_stepped;
        end
        tcacl_pkg::OP_ADVANCE, tcacl_pkg::OP_GLYPH: begin
          cursor_x <= x_advanced;
        end
        tcacl_pkg::OP_COLOR: begin
          current_color <= pop_data.code[5:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= do_pop && pop_data.op == tcacl_pkg::OP_GLYPH;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && do_pop && pop_data.op == tcacl_pkg::OP_GLYPH) begin
      glyph_x     <= tcacl_pkg::coord_to_out(cursor_x);
      glyph_y     <= tcacl_pkg::coord_to_out(cursor_y);
      glyph_index <= pop_data.code;
      red_level   <= current_color[5:4];
      green_level <= current_color[3:2];
      blue_level  <= current_color[1:0];
    end
  end

endmodule

// File: rtl/core/text_cursor_ansi_color_layout.sv
// Top level of the text cursor layout block with ANSI color sequences.
//
// Usage: text bytes and start requests enter on the in_valid/in_ready channel
// (cmd 0 places the cursor at start_x/start_y and resets the color to white,
// cmd 1 carries char_code). Each printable byte yields one glyph record on
// the out_valid/out_ready channel with its position, atlas index and color.
// Newline, space, escape sequences, control bytes and start requests give no
// record. Settings char_advance (index 0) and line_step (index 1) are to be
// written on the cfg channel only while the block is idle; the block itself
// does not enforce this; cfg_ready is always high. One request per cycle is
// taken while in_ready is high. A glyph byte is classified combinationally
// into the two-entry queue; a later pop updates the cursor in the back end
// and loads the output register, which must be free for a glyph to be popped.
// When the receiver stalls, the output register holds its record and the back
// end keeps retiring non-glyph requests; the queue fills and in_ready falls.
// Reset is synchronous: cursor and line start go to zero, color to white,
// any open escape sequence is dropped and the settings return to 9 and 4.
`timescale 1ns / 1ps
module text_cursor_ansi_color_layout (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [7:0]         char_code,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] glyph_x,
  output logic signed [15:0] glyph_y,
  output logic [7:0]         glyph_index,
  output logic [1:0]         red_level,
  output logic [1:0]         green_level,
  output logic [1:0]         blue_level
);

  logic              push_valid;
  logic              push_ready;
  tcacl_pkg::entry_t push_data;
  logic              pop_valid;
  logic              pop_ready;
  tcacl_pkg::entry_t pop_data;

  tcacl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .char_code  (char_code),
    .start_x    (start_x),
    .start_y    (start_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcacl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcacl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .glyph_x     (glyph_x),
    .glyph_y     (glyph_y),
    .glyph_index (glyph_index),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
  );

endmodule

// File: dv/layout_tb_pkg.sv
// Request codes and the glyph record type shared by the layout testbench files.
`timescale 1ns / 1ps
package layout_tb_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TEXT  = 1'b1;

  // No register lives at this index; writes to it must be ignored.
  localparam logic [7:0] REG_UNUSED = 8'hFE;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  atlas;
    logic [1:0]  red;
    logic [1:0]  green;
    logic [1:0]  blue;
  } glyph_rec_t;

endpackage

// File: dv/glyph_layout_checker.sv
// Checker that predicts glyph records from accepted requests and compares them.
`timescale 1ns / 1ps
module glyph_layout_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic [7:0]         char_code,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] glyph_x,
  input  logic signed [15:0] glyph_y,
  input  logic [7:0]         glyph_index,
  input  logic [1:0]         red_level,
  input  logic [1:0]         green_level,
  input  logic [1:0]         blue_level,
  output int                 errors,
  output int                 pending
);

  localparam int COORD_HI = (1 << (tcacl_pkg::COORD_WIDTH - 1)) - 1;
  localparam int COORD_LO = -COORD_HI - 1;

  layout_tb_pkg::glyph_rec_t glyph_q[$];
  int err_cnt = 0;

  logic signed [15:0] pen_x, pen_y, margin_x;
  logic [5:0] ink;
  int unsigned esc_len;
  logic [7:0] esc_seq [3];
  logic [5:0] advance_px;
  logic [7:0] step_px;

  function automatic logic signed [15:0] clamp_coord(input int v);
    if (v > COORD_HI) return 16'(COORD_HI);
    if (v < COORD_LO) return 16'(COORD_LO);
    return 16'(v);
  endfunction

  // Color select sequences: ESC [ 3 d m and ESC [ 9 d m, anything else leaves the ink.
  function automatic logic [5:0] sgr_ink(input logic [5:0] cur, input logic [7:0] lb,
                                          input logic [7:0] tens, input logic [7:0] digit,
                                          input logic [7:0] last);
    logic [1:0] lvl;
    logic [2:0] c;
    if (lb != tcacl_pkg::CHAR_LBRACKET || last != tcacl_pkg::CHAR_M) return cur;
    if (!(digit inside {[tcacl_pkg::CHAR_ZERO : tcacl_pkg::CHAR_SEVEN]})) return cur;
    c = 3'(digit - tcacl_pkg::CHAR_ZERO);
    if (tens == tcacl_pkg::CHAR_THREE) begin
      lvl = tcacl_pkg::LVL_HALF;
    end else if (tens == tcacl_pkg::CHAR_NINE) begin
      if (c == 3'd0) return tcacl_pkg::GREY_COLOR;
      lvl = tcacl_pkg::LVL_FULL;
    end else begin
      return cur;
    end
    return {c[0] ? lvl : tcacl_pkg::LVL_OFF, c[1] ? lvl : tcacl_pkg::LVL_OFF,
            c[2] ? lvl : tcacl_pkg::LVL_OFF};
  endfunction

  task automatic take_request(input logic c, input logic [7:0] ch,
                              input logic signed [15:0] sx, input logic signed [15:0] sy);
    layout_tb_pkg::glyph_rec_t rec;
    if (c == layout_tb_pkg::CMD_START) begin
      pen_x    = clamp_coord(int'(sx));
      pen_y    = clamp_coord(int'(sy));
      margin_x = pen_x;
      ink      = tcacl_pkg::WHITE_COLOR;
      esc_len  = 0;
      return;
    end
    if (esc_len != 0) begin
      if (esc_len >= 4) begin
        ink     = sgr_ink(ink, esc_seq[0], esc_seq[1], esc_seq[2], ch);
        esc_len = 0;
      end else begin
        esc_seq[2'(esc_len - 1)] = ch;
        esc_len++;
      end
      return;
    end
    if (ch == tcacl_pkg::NEWLINE) begin
      pen_x = margin_x;
      pen_y = clamp_coord(int'(pen_y) - int'(step_px));
    end else if (ch == tcacl_pkg::ESC_BYTE) begin
      esc_len = 1;
    end else if (ch == tcacl_pkg::SPACE) begin
      pen_x = clamp_coord(int'(pen_x) + int'(advance_px));
    end else if (ch >= tcacl_pkg::GLYPH_BASE) begin
      rec = '{x: pen_x, y: pen_y, atlas: ch - tcacl_pkg::GLYPH_BASE,
              red: ink[5:4], green: ink[3:2], blue: ink[1:0]};
      glyph_q.push_back(rec);
      pen_x = clamp_coord(int'(pen_x) + int'(advance_px));
    end
  endtask

  task automatic check_glyph();
    layout_tb_pkg::glyph_rec_t got, want;
    got = {glyph_x, glyph_y, glyph_index, red_level, green_level, blue_level};
    if (glyph_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected glyph: x=%0d y=%0d idx=%0d rgb=%0d/%0d/%0d",
                 $signed(got.x), $signed(got.y), got.atlas, got.red, got.green, got.blue);
      return;
    end
    want = glyph_q.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.atlas !== want.atlas ||
        got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $write("glyph mismatch: expected x=%0d y=%0d idx=%0d rgb=%0d/%0d/%0d,",
               $signed(want.x), $signed(want.y), want.atlas, want.red, want.green, want.blue);
        $display(" got x=%0d y=%0d idx=%0d rgb=%0d/%0d/%0d",
                 $signed(got.x), $signed(got.y), got.atlas, got.red, got.green, got.blue);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pen_x      = '0;
      pen_y      = '0;
      margin_x   = '0;
      ink        = tcacl_pkg::WHITE_COLOR;
      esc_len    = 0;
      advance_px = tcacl_pkg::CHAR_ADVANCE_RESET;
      step_px    = tcacl_pkg::LINE_STEP_RESET;
      glyph_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tcacl_pkg::REG_CHAR_ADVANCE) advance_px = cfg_data[5:0];
        else if (cfg_index == tcacl_pkg::REG_LINE_STEP) step_px = cfg_data;
      end
      // A record passes the queue and the output register before it leaves, so compare first.
      if (out_valid && out_ready) check_glyph();
      if (in_valid && in_ready) take_request(cmd, char_code, start_x, start_y);
    end
    pending <= glyph_q.size();
    errors  <= err_cnt;
  end

endmodule

// File: dv/tb_text_cursor_ansi_color_layout.sv
// Testbench top for the text cursor layout block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module tb_text_cursor_ansi_color_layout;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               cmd;
  logic [7:0]         char_code;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] glyph_x;
  logic signed [15:0] glyph_y;
  logic [7:0]         glyph_index;
  logic [1:0]         red_level;
  logic [1:0]         green_level;
  logic [1:0]         blue_level;

  int errors;
  int pending;
  int sent_cnt = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  text_cursor_ansi_color_layout uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .char_code(char_code),
    .start_x(start_x), .start_y(start_y),
    .out_valid(out_valid), .out_ready(out_ready), .glyph_x(glyph_x), .glyph_y(glyph_y),
    .glyph_index(glyph_index), .red_level(red_level), .green_level(green_level),
    .blue_level(blue_level)
  );

  glyph_layout_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .char_code(char_code),
    .start_x(start_x), .start_y(start_y),
    .out_valid(out_valid), .out_ready(out_ready), .glyph_x(glyph_x), .glyph_y(glyph_y),
    .glyph_index(glyph_index), .red_level(red_level), .green_level(green_level),
    .blue_level(blue_level), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1: return 16'h7FFF - 16'($urandom_range(0, 300));
      2: return 16'h8000 + 16'($urandom_range(0, 40));
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random ready bursts, plus one long hold-off on request.
  initial begin : rx_side
    int burst, g;
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken  = 1'b1;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_active = 1'b0;
      end
      burst = $urandom_range(1, 16);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      g = quiet_rx ? 0 : pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic c, input logic [7:0] ch,
                          input logic [15:0] x, input logic [15:0] y);
    int g;
    in_valid  <= 1'b1;
    cmd       <= c;
    char_code <= ch;
    start_x   <= x;
    start_y   <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    g = quiet_tx ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_req(layout_tb_pkg::CMD_TEXT, ch, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_start(input logic [15:0] x, input logic [15:0] y);
    send_req(layout_tb_pkg::CMD_START, 8'($urandom), x, y);
  endtask

  task automatic send_seq(input logic [7:0] b0, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] b3);
    send_byte(tcacl_pkg::ESC_BYTE);
    send_byte(b0);
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
  endtask

  // Drop valid and wait until every predicted glyph has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_text(input int n);
    int target, r;
    logic [7:0] b [4];
    target = sent_cnt + n;
    while (sent_cnt < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_byte(8'($urandom_range(33, 255)));
      end else if (r < 55) begin
        send_byte(tcacl_pkg::SPACE);
      end else if (r < 62) begin
        send_byte(tcacl_pkg::NEWLINE);
      end else if (r < 74) begin
        send_seq(tcacl_pkg::CHAR_LBRACKET,
                 ($urandom_range(0, 1) != 0) ? tcacl_pkg::CHAR_NINE : tcacl_pkg::CHAR_THREE,
                 tcacl_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)), tcacl_pkg::CHAR_M);
      end else if (r < 79) begin
        // Near-valid color sequence with one byte corrupted.
        b[0] = tcacl_pkg::CHAR_LBRACKET;
        b[1] = ($urandom_range(0, 1) != 0) ? tcacl_pkg::CHAR_NINE : tcacl_pkg::CHAR_THREE;
        b[2] = tcacl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
        b[3] = tcacl_pkg::CHAR_M;
        b[2'($urandom_range(0, 3))] = 8'($urandom);
        send_seq(b[0], b[1], b[2], b[3]);
      end else if (r < 84) begin
        send_byte(8'($urandom_range(0, 31)));
      end else if (r < 89) begin
        send_start(pick_coord(), pick_coord());
      end else if (r < 92) begin
        send_byte(tcacl_pkg::ESC_BYTE);
        send_byte(tcacl_pkg::CHAR_LBRACKET);
        send_start(pick_coord(), pick_coord());
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] adv, input logic [7:0] step, input int n,
                           input bit quiet);
    drain();
    write_reg(tcacl_pkg::REG_CHAR_ADVANCE, adv);
    write_reg(tcacl_pkg::REG_LINE_STEP, step);
    write_reg(layout_tb_pkg::REG_UNUSED, 8'($urandom));
    quiet_tx = quiet;
    quiet_rx = quiet;
    send_start(pick_coord(), pick_coord());
    random_text(n);
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cmd       <= layout_tb_pkg::CMD_START;
    char_code <= '0;
    start_x   <= '0;
    start_y   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturation at both edges, atlas ends, colors and sequence corner cases.
    send_start(16'sd32750, -16'sd32766);
    send_byte("A");
    send_byte(tcacl_pkg::GLYPH_BASE);
    send_byte(8'hFF);
    send_byte(tcacl_pkg::SPACE);
    send_byte(tcacl_pkg::NEWLINE);
    send_byte(tcacl_pkg::NEWLINE);
    send_seq(tcacl_pkg::CHAR_LBRACKET, tcacl_pkg::CHAR_THREE, tcacl_pkg::CHAR_ZERO + 8'd1,
             tcacl_pkg::CHAR_M);
    send_byte("B");
    send_seq(tcacl_pkg::CHAR_LBRACKET, tcacl_pkg::CHAR_NINE, tcacl_pkg::CHAR_ZERO,
             tcacl_pkg::CHAR_M);
    send_byte(8'h7F);
    // ESC and newline inside a sequence are just sequence bytes.
    send_seq(tcacl_pkg::ESC_BYTE, tcacl_pkg::NEWLINE, tcacl_pkg::CHAR_THREE, tcacl_pkg::CHAR_M);
    send_byte(8'h00);
    send_byte("C");
    // A start request abandons the open sequence.
    send_byte(tcacl_pkg::ESC_BYTE);
    send_byte(tcacl_pkg::CHAR_LBRACKET);
    send_start(16'h8000, 16'h7FFF);
    send_byte("Z");

    run_phase(8'hFF, 8'hFF, 290, 1'b1);
    run_phase(8'h01, 8'h00, 290, 1'b0);
    run_phase(8'hC0, 8'h80, 290, 1'b0);
    run_phase(8'($urandom_range(1, 63)), 8'($urandom), 290, 1'b0);

    // Receiver holds off while the sender keeps offering requests.
    run_phase(8'(tcacl_pkg::CHAR_ADVANCE_RESET), tcacl_pkg::LINE_STEP_RESET, 150, 1'b0);
    in_valid <= 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    quiet_tx = 1'b1;
    random_text(100);
    quiet_tx = 1'b0;
    random_text(140);

    run_phase(8'hE5, 8'h3C, 290, 1'b0);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
